FILE: hdl/sender_table_lru_lookup_macros.svh
// assertion macros for the sender table lookup block
// used by the controller and datapath, expects i_clk and i_rst_n in scope
`ifndef SENDER_TABLE_LRU_LOOKUP_MACROS_SVH
`define SENDER_TABLE_LRU_LOOKUP_MACROS_SVH

// same-cycle implication
`define STLL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("stll assertion failed");

// next-cycle implication
`define STLL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stll assertion failed");

`endif

FILE: hdl/stll_pkg.sv
// shared constants and controller/datapath interface types
// for the sender table lookup block, no dependencies
`default_nettype none

package stll_pkg;

    localparam int ID_W           = 16;
    localparam int AGE_W          = 8;
    localparam int SLOT_W         = 3;
    localparam int NONCE_W        = 6;
    localparam int DEF_ENTRIES    = 8;
    localparam int DEF_NONCE_BITS = 6;

    // commands from controller to datapath
    typedef struct packed {
        logic clr;
        logic rd_en;
        logic scan;
        logic k_clr;
        logic sweep_wr;
        logic wr_new;
        logic out_load;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic master;
        logic hit;
        logic last;
        logic age_nz;
        logic found;
        logic out_full;
    } t_st;

endpackage

`default_nettype wire

FILE: hdl/stll_dp.sv
// datapath: master id register, table memory, slot walk and output register
// depends on stll_pkg and sender_table_lru_lookup_macros.svh
`default_nettype none

`include "sender_table_lru_lookup_macros.svh"

module stll_dp #(
    parameter int ENTRIES    = stll_pkg::DEF_ENTRIES,
    parameter int NONCE_BITS = stll_pkg::DEF_NONCE_BITS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [stll_pkg::ID_W-1:0]        i_cfg_data,
    input  wire  [stll_pkg::ID_W-1:0]        i_sender_id,
    input  wire  [stll_pkg::NONCE_W-1:0]     i_fresh_expected_nonce,
    input  wire  [stll_pkg::NONCE_W-1:0]     i_fresh_send_nonce,
    input  wire                              i_out_stall,
    input  stll_pkg::t_cmd                   i_cmd,
    output stll_pkg::t_st                    o_st,
    output logic                             o_out_valid,
    output logic                             o_from_master,
    output logic [stll_pkg::SLOT_W-1:0]      o_slot,
    output logic                             o_new_entry,
    output logic [stll_pkg::NONCE_W-1:0]     o_expected_nonce,
    output logic [stll_pkg::NONCE_W-1:0]     o_send_nonce
);
    import stll_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // table memory
    logic [ID_W-1:0]       mem_id  [ENTRIES];
    logic [AGE_W-1:0]      mem_age [ENTRIES];
    logic [NONCE_BITS-1:0] mem_en  [ENTRIES];
    logic [NONCE_BITS-1:0] mem_sn  [ENTRIES];
    logic [ENTRIES-1:0]    r_vld;

    logic [ID_W-1:0]       r_master_id;
    logic [ID_W-1:0]       r_id;
    logic [NONCE_BITS-1:0] r_fe;
    logic [NONCE_BITS-1:0] r_fs;
    logic                  r_master;
    logic                  r_found;
    logic [AGE_W-1:0]      r_age;
    logic [NONCE_BITS-1:0] r_en;
    logic [NONCE_BITS-1:0] r_sn;
    logic [IDX_W-1:0]      r_k;
    logic [IDX_W-1:0]      r_sel;
    logic [IDX_W-1:0]      r_oldest;

    logic [ID_W-1:0]       r_rd_id;
    logic [AGE_W-1:0]      r_rd_age;
    logic [NONCE_BITS-1:0] r_rd_en;
    logic [NONCE_BITS-1:0] r_rd_sn;
    logic                  r_rd_vld;

    logic                  r_o_valid;
    logic                  r_o_master;
    logic [SLOT_W-1:0]     r_o_slot;
    logic                  r_o_new;
    logic [NONCE_W-1:0]    r_o_en;
    logic [NONCE_W-1:0]    r_o_sn;

    logic [ID_W-1:0]       rd_id;
    logic [AGE_W-1:0]      rd_age;
    logic [NONCE_BITS-1:0] rd_en;
    logic [NONCE_BITS-1:0] rd_sn;
    logic                  hit;
    logic                  older;
    logic                  last;

    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [ID_W-1:0]       w_id;
    logic [AGE_W-1:0]      w_age;
    logic [NONCE_BITS-1:0] w_en;
    logic [NONCE_BITS-1:0] w_sn;

    // entries never written read as zero
    assign rd_id  = r_rd_vld ? r_rd_id  : '0;
    assign rd_age = r_rd_vld ? r_rd_age : '0;
    assign rd_en  = r_rd_vld ? r_rd_en  : '0;
    assign rd_sn  = r_rd_vld ? r_rd_sn  : '0;

    assign hit   = (rd_id == r_id);
    assign older = (r_age < rd_age);
    assign last  = (r_k == LAST_IDX);

    always_comb begin
        we    = i_cmd.sweep_wr | i_cmd.wr_new;
        waddr = i_cmd.wr_new ? r_sel : r_k;
        w_id  = r_id;
        w_age = '0;
        w_en  = r_fe;
        w_sn  = r_fs;
        if (i_cmd.sweep_wr) begin
            if (r_k == r_sel) begin
                if (r_found) begin
                    w_id = rd_id;
                    w_en = rd_en;
                    w_sn = rd_sn;
                end
            end else begin
                w_id  = rd_id;
                w_age = rd_age + AGE_W'(1);
                w_en  = rd_en;
                w_sn  = rd_sn;
            end
        end
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_id[waddr]  <= w_id;
            mem_age[waddr] <= w_age;
            mem_en[waddr]  <= w_en;
            mem_sn[waddr]  <= w_sn;
        end
        if (i_cmd.rd_en) begin
            r_rd_id  <= mem_id[r_k];
            r_rd_age <= mem_age[r_k];
            r_rd_en  <= mem_en[r_k];
            r_rd_sn  <= mem_sn[r_k];
            r_rd_vld <= r_vld[r_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_master_id <= '0;
        end else begin
            if (we) begin
                r_vld[waddr] <= 1'b1;
            end
            if (i_cfg_we) begin
                r_master_id <= i_cfg_data;
            end
        end
    end

    // item capture and slot walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_id     <= i_sender_id;
            r_fe     <= NONCE_BITS'(i_fresh_expected_nonce);
            r_fs     <= NONCE_BITS'(i_fresh_send_nonce);
            r_master <= (i_sender_id == r_master_id);
            r_found  <= 1'b0;
            r_age    <= '0;
            r_k      <= '0;
            r_sel    <= '0;
            r_oldest <= '0;
        end else if (i_cmd.scan) begin
            if (hit) begin
                r_found <= 1'b1;
                r_sel   <= r_k;
                r_age   <= rd_age;
                r_en    <= rd_en;
                r_sn    <= rd_sn;
            end else begin
                if (older) begin
                    r_age    <= rd_age;
                    r_oldest <= r_k;
                end
                if (last) begin
                    r_sel <= older ? r_k : r_oldest;
                end else begin
                    r_k <= r_k + IDX_W'(1);
                end
            end
        end else if (i_cmd.k_clr) begin
            r_k <= '0;
        end else if (i_cmd.sweep_wr) begin
            r_k <= r_k + IDX_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_master <= r_master;
            if (r_master) begin
                r_o_slot <= '0;
                r_o_new  <= 1'b0;
                r_o_en   <= '0;
                r_o_sn   <= '0;
            end else begin
                r_o_slot <= SLOT_W'(r_sel);
                r_o_new  <= !r_found;
                r_o_en   <= r_found ? NONCE_W'(r_en) : NONCE_W'(r_fe);
                r_o_sn   <= r_found ? NONCE_W'(r_sn) : NONCE_W'(r_fs);
            end
        end
    end

    assign o_st.master   = r_master;
    assign o_st.hit      = hit;
    assign o_st.last     = last;
    assign o_st.age_nz   = (r_age != '0);
    assign o_st.found    = r_found;
    assign o_st.out_full = r_o_valid & i_out_stall;

    assign o_out_valid      = r_o_valid;
    assign o_from_master    = r_o_master;
    assign o_slot           = r_o_slot;
    assign o_new_entry      = r_o_new;
    assign o_expected_nonce = r_o_en;
    assign o_send_nonce     = r_o_sn;

    `STLL_ASSERT_IMP(a_master_zero, r_o_valid && r_o_master, r_o_slot == '0 && !r_o_new && r_o_en == '0 && r_o_sn == '0)
    `STLL_ASSERT_NXT(a_load_valid, i_cmd.out_load, r_o_valid)
    `STLL_ASSERT_IMP(a_one_port_op, we, !i_cmd.rd_en)

endmodule

`default_nettype wire

FILE: hdl/stll_ctl.sv
// controller: sequences capture, slot walk, age sweep and result load
// depends on stll_pkg and sender_table_lru_lookup_macros.svh
`default_nettype none

`include "sender_table_lru_lookup_macros.svh"

module stll_ctl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_stall,
    input  stll_pkg::t_st   i_st,
    output stll_pkg::t_cmd  o_cmd
);
    import stll_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_DEC  = 3'd4;
    localparam logic [2:0] S_SWRD = 3'd5;
    localparam logic [2:0] S_SWWR = 3'd6;
    localparam logic [2:0] S_WNEW = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out;
    logic       n_out;

    assign o_in_stall = (r_state != S_IDLE) | r_out;

    always_comb begin
        n_state = r_state;
        n_out   = r_out;
        o_cmd   = '0;
        if (r_out) begin
            // result waits for room in the output register
            if (!i_st.out_full) begin
                o_cmd.out_load = 1'b1;
                n_out          = 1'b0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        o_cmd.clr = 1'b1;
                        n_state   = S_CHK;
                    end
                end
                S_CHK: begin
                    if (i_st.master) begin
                        n_state = S_IDLE;
                        n_out   = 1'b1;
                    end else begin
                        n_state = S_RD;
                    end
                end
                S_RD: begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_CMP;
                end
                S_CMP: begin
                    o_cmd.scan = 1'b1;
                    n_state    = (i_st.hit || i_st.last) ? S_DEC : S_RD;
                end
                S_DEC: begin
                    o_cmd.k_clr = 1'b1;
                    if (i_st.age_nz) begin
                        n_state = S_SWRD;
                    end else if (!i_st.found) begin
                        n_state = S_WNEW;
                    end else begin
                        n_state = S_IDLE;
                        n_out   = 1'b1;
                    end
                end
                S_SWRD: begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_SWWR;
                end
                S_SWWR: begin
                    o_cmd.sweep_wr = 1'b1;
                    if (i_st.last) begin
                        n_state = S_IDLE;
                        n_out   = 1'b1;
                    end else begin
                        n_state = S_SWRD;
                    end
                end
                S_WNEW: begin
                    o_cmd.wr_new = 1'b1;
                    n_state      = S_IDLE;
                    n_out        = 1'b1;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out   <= n_out;
        end
    end

    `STLL_ASSERT_IMP(a_load_room, o_cmd.out_load, !i_st.out_full)
    `STLL_ASSERT_IMP(a_new_on_miss, o_cmd.wr_new, !i_st.found)
    `STLL_ASSERT_NXT(a_master_skip, r_state == S_CHK && !r_out && i_st.master, r_out && r_state == S_IDLE)

endmodule

`default_nettype wire

FILE: hdl/sender_table_lru_lookup.sv
// Master hit: the result skips the table and is loaded into the output register once there is room.
// Table lookup: a read and a compare per slot walked until the first match (all slots on a miss),
// then a decide step, then a read and a write per slot for the age sweep when ages change (a single
// new-entry write for a plain replacement), then the load. One item at a time, set by the slot walk
// over the single table memory port; the next item is taken the cycle after the load.
// Synchronous active-low reset empties the table (every slot reads as zero) and clears master id.
`default_nettype none

module sender_table_lru_lookup #(
    parameter int ENTRIES    = stll_pkg::DEF_ENTRIES,
    parameter int NONCE_BITS = stll_pkg::DEF_NONCE_BITS
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire  [stll_pkg::ID_W-1:0]     i_cfg_data,
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire  [stll_pkg::ID_W-1:0]     i_sender_id,
    input  wire  [stll_pkg::NONCE_W-1:0]  i_fresh_expected_nonce,
    input  wire  [stll_pkg::NONCE_W-1:0]  i_fresh_send_nonce,
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output logic                          o_from_master,
    output logic [stll_pkg::SLOT_W-1:0]   o_slot,
    output logic                          o_new_entry,
    output logic [stll_pkg::NONCE_W-1:0]  o_expected_nonce,
    output logic [stll_pkg::NONCE_W-1:0]  o_send_nonce
);
    import stll_pkg::*;

    t_cmd cmd;
    t_st  st;

    stll_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    stll_dp #(
        .ENTRIES    (ENTRIES),
        .NONCE_BITS (NONCE_BITS)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_data             (i_cfg_data),
        .i_sender_id            (i_sender_id),
        .i_fresh_expected_nonce (i_fresh_expected_nonce),
        .i_fresh_send_nonce     (i_fresh_send_nonce),
        .i_out_stall            (i_out_stall),
        .i_cmd                  (cmd),
        .o_st                   (st),
        .o_out_valid            (o_out_valid),
        .o_from_master          (o_from_master),
        .o_slot                 (o_slot),
        .o_new_entry            (o_new_entry),
        .o_expected_nonce       (o_expected_nonce),
        .o_send_nonce           (o_send_nonce)
    );

endmodule

`default_nettype wire
